@@ rtl/dgpr_pkg.sv @@
// Package for the dual game port registers: item types, codes and reset values.
`default_nettype none
package dgpr_pkg;

  typedef enum logic [1:0] {
    KIND_READ     = 2'd0,
    KIND_TEST_WR  = 2'd1,
    KIND_MOUSE    = 2'd2,
    KIND_JOYSTICK = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    SEL_PORT0_DATA = 3'd0,
    SEL_PORT1_DATA = 3'd1,
    SEL_POT0       = 3'd2,
    SEL_POT1       = 3'd3,
    SEL_POT_STATUS = 3'd4
  } reg_sel_e;

  typedef enum logic [2:0] {
    CFG_PORT0_DEVICE = 3'd0,
    CFG_PORT1_DEVICE = 3'd1,
    CFG_AUTOFIRE0    = 3'd2,
    CFG_AUTOFIRE1    = 3'd3,
    CFG_POTGO_BASE   = 3'd4
  } cfg_idx_e;

  localparam int unsigned NumPorts   = 2;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 16;

  localparam logic [3:0]  MouseCode      = 4'd1;
  localparam logic [3:0]  Port0DevReset  = 4'd1;
  localparam logic [3:0]  Port1DevReset  = 4'd0;
  localparam logic [15:0] PotgoReset     = 16'hffff;
  localparam logic [15:0] PotgoMask      = 16'hbbff;
  localparam logic [15:0] PotStep        = 16'h0100;
  localparam logic [15:0] Sec0Bit        = 16'h0400;
  localparam logic [15:0] Sec1Bit        = 16'h4000;
  localparam logic [31:0] StepPos        = 32'd127;
  localparam logic [31:0] StepNeg        = 32'hffffff81;

  typedef struct packed {
    logic [1:0]         kind;
    logic [2:0]         reg_select;
    logic [15:0]        write_data;
    logic [3:0]         device;
    logic signed [15:0] move_x;
    logic signed [15:0] move_y;
    logic               dir_left;
    logic               dir_up;
    logic               dir_right;
    logic               dir_down;
    logic               fire_primary;
    logic               fire_secondary;
  } in_item_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic [1:0]  primary_fire_mask;
  } out_item_t;

endpackage
`default_nettype wire

@@ rtl/dual_game_port_registers.sv @@
// Dual game port registers: mouse counters, joystick flags, pot counters, bus reads.
//
//   channel | direction | handshake             | payload
//   in      | input     | in_valid_i/in_stall_o | in_item_i  (dgpr_pkg::in_item_t)
//   out     | output    | out_valid_o/out_stall_i | out_item_o (dgpr_pkg::out_item_t)
//   cfg     | input     | cfg_we_i              | cfg_idx_i, cfg_data_i
//
// One item per cycle; the port state is updated at acceptance and a register read's
// item appears in the output register on the next cycle.
// The input stalls only while the output register holds an item that is stalled.
// Reset clears all port state and loads the default configuration.
`default_nettype none
module dual_game_port_registers (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output      logic                                in_stall_o,
  input  wire dgpr_pkg::in_item_t                  in_item_i,
  output      logic                                out_valid_o,
  input  wire logic                                out_stall_i,
  output      dgpr_pkg::out_item_t                 out_item_o,
  input  wire logic                                cfg_we_i,
  input  wire logic [dgpr_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  wire logic [dgpr_pkg::CfgDataW-1:0]       cfg_data_i
);

  localparam int unsigned NP = dgpr_pkg::NumPorts;

  logic [3:0]  dev_q      [NP];
  logic        autofire_q [NP];
  logic [15:0] potgo_q;

  logic [31:0] pos_x_q  [NP], pos_x_d  [NP];
  logic [31:0] pos_y_q  [NP], pos_y_d  [NP];
  logic [31:0] seen_x_q [NP], seen_x_d [NP];
  logic [31:0] seen_y_q [NP], seen_y_d [NP];
  logic [15:0] pot_q    [NP], pot_d    [NP];
  logic        fire1_q  [NP], fire1_d  [NP];
  logic        fire2_q  [NP], fire2_d  [NP];
  logic [3:0]  dir_q    [NP], dir_d    [NP];

  logic                out_valid_q, out_valid_d;
  dgpr_pkg::out_item_t out_item_q, out_item_d;

  logic        accept;
  logic [31:0] step_x [NP];
  logic [31:0] step_y [NP];
  logic [31:0] nseen_x [NP];
  logic [31:0] nseen_y [NP];
  logic [15:0] port_word [NP];
  logic [15:0] joy_word [NP];
  logic [1:0]  fire2_tog;
  logic [15:0] status_word;
  logic [15:0] rd_data;
  logic [31:0] tw_x, tw_y;
  logic        is_read, is_event;

  function automatic logic [31:0] clamp_step(input logic [31:0] d);
    logic [31:0] r;
    r = d;
    if (!d[31]) begin
      if (d > dgpr_pkg::StepPos) r = dgpr_pkg::StepPos;
    end else if (d < dgpr_pkg::StepNeg) begin
      r = dgpr_pkg::StepNeg;
    end
    return r;
  endfunction

  assign in_stall_o  = out_valid_q & out_stall_i;
  assign accept      = in_valid_i & ~in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  assign is_read  = (in_item_i.kind == dgpr_pkg::KIND_READ);
  assign is_event = (in_item_i.kind == dgpr_pkg::KIND_MOUSE) ||
                    (in_item_i.kind == dgpr_pkg::KIND_JOYSTICK);
  assign tw_x = {{24{in_item_i.write_data[7]}}, in_item_i.write_data[7:0]};
  assign tw_y = {{24{in_item_i.write_data[15]}}, in_item_i.write_data[15:8]};

  always_comb begin
    for (int p = 0; p < NP; p++) begin
      step_x[p]  = clamp_step(pos_x_q[p] - seen_x_q[p]);
      step_y[p]  = clamp_step(pos_y_q[p] - seen_y_q[p]);
      nseen_x[p] = seen_x_q[p] + step_x[p];
      nseen_y[p] = seen_y_q[p] + step_y[p];
      joy_word[p] = 16'h0000;
      if (dir_q[p][2]) joy_word[p] = joy_word[p] | 16'h0003;
      if (dir_q[p][0]) joy_word[p] = joy_word[p] | 16'h0300;
      if (dir_q[p][1]) joy_word[p] = joy_word[p] ^ 16'h0100;
      if (dir_q[p][3]) joy_word[p] = joy_word[p] ^ 16'h0001;
      port_word[p] = (dev_q[p] == dgpr_pkg::MouseCode) ?
                     {nseen_y[p][7:0], nseen_x[p][7:0]} : joy_word[p];
      fire2_tog[p] = fire2_q[p] ^ autofire_q[p];
    end
    status_word = potgo_q & dgpr_pkg::PotgoMask;
    if (!fire2_tog[0]) status_word = status_word | dgpr_pkg::Sec0Bit;
    if (!fire2_tog[1]) status_word = status_word | dgpr_pkg::Sec1Bit;
  end

  always_comb begin
    rd_data = 16'h0000;
    for (int p = 0; p < NP; p++) begin
      pos_x_d[p]  = pos_x_q[p];
      pos_y_d[p]  = pos_y_q[p];
      seen_x_d[p] = seen_x_q[p];
      seen_y_d[p] = seen_y_q[p];
      pot_d[p]    = pot_q[p];
      fire1_d[p]  = fire1_q[p];
      fire2_d[p]  = fire2_q[p];
      dir_d[p]    = dir_q[p];
    end
    if (accept) begin
      if (is_read) begin
        unique case (in_item_i.reg_select)
          dgpr_pkg::SEL_PORT0_DATA: begin
            rd_data = port_word[0];
            if (dev_q[0] == dgpr_pkg::MouseCode) begin
              seen_x_d[0] = nseen_x[0];
              seen_y_d[0] = nseen_y[0];
            end
          end
          dgpr_pkg::SEL_PORT1_DATA: begin
            rd_data = port_word[1];
            if (dev_q[1] == dgpr_pkg::MouseCode) begin
              seen_x_d[1] = nseen_x[1];
              seen_y_d[1] = nseen_y[1];
            end
          end
          dgpr_pkg::SEL_POT0: rd_data = pot_q[0];
          dgpr_pkg::SEL_POT1: rd_data = pot_q[1];
          dgpr_pkg::SEL_POT_STATUS: begin
            rd_data = status_word;
            fire2_d[0] = fire2_tog[0];
            fire2_d[1] = fire2_tog[1];
          end
          default: rd_data = 16'h0000;
        endcase
      end else if (in_item_i.kind == dgpr_pkg::KIND_TEST_WR) begin
        for (int p = 0; p < NP; p++) begin
          pos_x_d[p]  = tw_x;
          seen_x_d[p] = tw_x;
          pos_y_d[p]  = tw_y;
          seen_y_d[p] = tw_y;
        end
      end else if (is_event) begin
        for (int p = 0; p < NP; p++) begin
          if (dev_q[p] == in_item_i.device) begin
            if (!fire2_q[p] && in_item_i.fire_secondary) begin
              pot_d[p] = pot_q[p] + dgpr_pkg::PotStep;
            end
            fire1_d[p] = in_item_i.fire_primary;
            fire2_d[p] = in_item_i.fire_secondary;
            if (in_item_i.kind == dgpr_pkg::KIND_MOUSE) begin
              pos_x_d[p] = pos_x_q[p] + {{16{in_item_i.move_x[15]}}, in_item_i.move_x};
              pos_y_d[p] = pos_y_q[p] + {{16{in_item_i.move_y[15]}}, in_item_i.move_y};
            end else begin
              dir_d[p] = {in_item_i.dir_down, in_item_i.dir_right,
                          in_item_i.dir_up, in_item_i.dir_left};
            end
          end
        end
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q & out_stall_i;
    out_item_d  = out_item_q;
    if (accept && is_read) begin
      out_valid_d                  = 1'b1;
      out_item_d.read_data         = rd_data;
      out_item_d.primary_fire_mask = {fire1_q[1], fire1_q[0]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_q[0]      <= dgpr_pkg::Port0DevReset;
      dev_q[1]      <= dgpr_pkg::Port1DevReset;
      autofire_q[0] <= 1'b0;
      autofire_q[1] <= 1'b0;
      potgo_q       <= dgpr_pkg::PotgoReset;
      for (int p = 0; p < NP; p++) begin
        pos_x_q[p]  <= '0;
        pos_y_q[p]  <= '0;
        seen_x_q[p] <= '0;
        seen_y_q[p] <= '0;
        pot_q[p]    <= '0;
        fire1_q[p]  <= 1'b0;
        fire2_q[p]  <= 1'b0;
        dir_q[p]    <= '0;
      end
      out_valid_q <= 1'b0;
    end else begin
      for (int p = 0; p < NP; p++) begin
        pos_x_q[p]  <= pos_x_d[p];
        pos_y_q[p]  <= pos_y_d[p];
        seen_x_q[p] <= seen_x_d[p];
        seen_y_q[p] <= seen_y_d[p];
        pot_q[p]    <= pot_d[p];
        fire1_q[p]  <= fire1_d[p];
        fire2_q[p]  <= fire2_d[p];
        dir_q[p]    <= dir_d[p];
      end
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          dgpr_pkg::CFG_PORT0_DEVICE: dev_q[0]      <= cfg_data_i[3:0];
          dgpr_pkg::CFG_PORT1_DEVICE: dev_q[1]      <= cfg_data_i[3:0];
          dgpr_pkg::CFG_AUTOFIRE0:    autofire_q[0] <= cfg_data_i[0];
          dgpr_pkg::CFG_AUTOFIRE1:    autofire_q[1] <= cfg_data_i[0];
          dgpr_pkg::CFG_POTGO_BASE:   potgo_q       <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_item_q <= out_item_d;
  end

endmodule
`default_nettype wire

@@ bench/tb_top.sv @@
// Testbench for the dual game port registers: directed and random items checked by a predictor.
`timescale 1ns / 1ps
module tb_top;

  localparam int unsigned CycleLimit  = 200000;
  localparam logic [2:0]  SelUnusedLo = 3'd5;
  localparam logic [2:0]  SelUnusedHi = 3'd7;
  localparam logic [3:0]  NoPortDev   = 4'd5;

  logic                          clk_i;
  logic                          rst_ni      = 1'b0;
  logic                          in_valid_i  = 1'b0;
  logic                          in_stall_o;
  dgpr_pkg::in_item_t            in_item_i   = '0;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  dgpr_pkg::out_item_t           out_item_o;
  logic                          cfg_we_i    = 1'b0;
  logic [dgpr_pkg::CfgIdxW-1:0]  cfg_idx_i   = '0;
  logic [dgpr_pkg::CfgDataW-1:0] cfg_data_i  = '0;

  dual_game_port_registers u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  // predicted port state and configuration
  logic [3:0]  port_dev_cfg [2];
  logic        autofire_cfg [2];
  logic [15:0] potgo_cfg;
  logic [31:0] pos_x [2];
  logic [31:0] pos_y [2];
  logic [31:0] seen_x [2];
  logic [31:0] seen_y [2];
  logic [15:0] pot_cnt [2];
  logic        fire_main [2];
  logic        fire_second [2];
  logic [3:0]  dir_flags [2];

  dgpr_pkg::out_item_t pending_reads [$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  int unsigned send_idle_pct  = 35;
  int unsigned recv_stall_pct = 35;
  int unsigned hold_left      = 0;
  bit          hold_off_req   = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  function automatic logic [31:0] step_toward(input logic [31:0] d);
    if ($signed(d) > $signed(dgpr_pkg::StepPos)) return dgpr_pkg::StepPos;
    if ($signed(d) < $signed(dgpr_pkg::StepNeg)) return dgpr_pkg::StepNeg;
    return d;
  endfunction

  function automatic logic [15:0] read_port_data(input int p);
    logic [15:0] r;
    r = '0;
    if (port_dev_cfg[p] == dgpr_pkg::MouseCode) begin
      seen_x[p] += step_toward(pos_x[p] - seen_x[p]);
      seen_y[p] += step_toward(pos_y[p] - seen_y[p]);
      r = {seen_y[p][7:0], seen_x[p][7:0]};
    end else begin
      // flags: bit0 left, bit1 up, bit2 right, bit3 down
      if (dir_flags[p][2]) r |= 16'h0003;
      if (dir_flags[p][0]) r |= 16'h0300;
      if (dir_flags[p][1]) r ^= 16'h0100;
      if (dir_flags[p][3]) r ^= 16'h0001;
    end
    return r;
  endfunction

  task automatic predict_port_regs(input dgpr_pkg::in_item_t it, output bit has_res,
                                   output dgpr_pkg::out_item_t res);
    logic [31:0] mx;
    logic [31:0] my;
    logic [15:0] v;
    has_res = 1'b0;
    res     = '0;
    v       = '0;
    mx      = {{16{it.move_x[15]}}, it.move_x};
    my      = {{16{it.move_y[15]}}, it.move_y};
    case (it.kind)
      dgpr_pkg::KIND_READ: begin
        has_res = 1'b1;
        case (it.reg_select)
          dgpr_pkg::SEL_PORT0_DATA: v = read_port_data(0);
          dgpr_pkg::SEL_PORT1_DATA: v = read_port_data(1);
          dgpr_pkg::SEL_POT0:       v = pot_cnt[0];
          dgpr_pkg::SEL_POT1:       v = pot_cnt[1];
          dgpr_pkg::SEL_POT_STATUS: begin
            v = potgo_cfg & dgpr_pkg::PotgoMask;
            for (int p = 0; p < 2; p++) begin
              if (autofire_cfg[p]) fire_second[p] = ~fire_second[p];
            end
            if (!fire_second[0]) v |= dgpr_pkg::Sec0Bit;
            if (!fire_second[1]) v |= dgpr_pkg::Sec1Bit;
          end
          default: v = '0;
        endcase
        res.read_data         = v;
        res.primary_fire_mask = {fire_main[1], fire_main[0]};
      end
      dgpr_pkg::KIND_TEST_WR: begin
        for (int p = 0; p < 2; p++) begin
          pos_x[p]  = {{24{it.write_data[7]}}, it.write_data[7:0]};
          pos_y[p]  = {{24{it.write_data[15]}}, it.write_data[15:8]};
          seen_x[p] = pos_x[p];
          seen_y[p] = pos_y[p];
        end
      end
      default: begin
        for (int p = 0; p < 2; p++) begin
          if (port_dev_cfg[p] == it.device) begin
            if (!fire_second[p] && it.fire_secondary) pot_cnt[p] += dgpr_pkg::PotStep;
            fire_main[p]   = it.fire_primary;
            fire_second[p] = it.fire_secondary;
            if (it.kind == dgpr_pkg::KIND_MOUSE) begin
              pos_x[p] += mx;
              pos_y[p] += my;
            end else begin
              dir_flags[p] = {it.dir_down, it.dir_right, it.dir_up, it.dir_left};
            end
          end
        end
      end
    endcase
  endtask

  // prediction at acceptance
  always @(posedge clk_i) begin
    bit                  has_res;
    dgpr_pkg::out_item_t res;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      predict_port_regs(in_item_i, has_res, res);
      if (has_res) pending_reads.push_back(res);
    end
  end

  always @(posedge clk_i) begin
    dgpr_pkg::out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_reads.size() == 0) begin
        report_mismatch($sformatf("unexpected item, read_data %h", out_item_o.read_data));
      end else begin
        want = pending_reads.pop_front();
        if (out_item_o.read_data !== want.read_data)
          report_mismatch($sformatf("read_data %h, expected %h",
                                    out_item_o.read_data, want.read_data));
        if (out_item_o.primary_fire_mask !== want.primary_fire_mask)
          report_mismatch($sformatf("primary_fire_mask %b, expected %b",
                                    out_item_o.primary_fire_mask,
                                    want.primary_fire_mask));
      end
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_off_req) begin
      hold_left    = 120;
      hold_off_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic send_item(input dgpr_pkg::in_item_t it);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic wait_reads_done();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_reads.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_cfg(input dgpr_pkg::cfg_idx_e idx, input logic [15:0] data);
    case (idx)
      dgpr_pkg::CFG_PORT0_DEVICE: port_dev_cfg[0] = data[3:0];
      dgpr_pkg::CFG_PORT1_DEVICE: port_dev_cfg[1] = data[3:0];
      dgpr_pkg::CFG_AUTOFIRE0:    autofire_cfg[0] = data[0];
      dgpr_pkg::CFG_AUTOFIRE1:    autofire_cfg[1] = data[0];
      default:                    potgo_cfg       = data;
    endcase
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
  endtask

  task automatic apply_setting(input logic [3:0] dev0, input logic [3:0] dev1,
                               input logic af0, input logic af1,
                               input logic [15:0] base);
    wait_reads_done();
    write_cfg(dgpr_pkg::CFG_PORT0_DEVICE, {12'd0, dev0});
    write_cfg(dgpr_pkg::CFG_PORT1_DEVICE, {12'd0, dev1});
    write_cfg(dgpr_pkg::CFG_AUTOFIRE0, {15'd0, af0});
    write_cfg(dgpr_pkg::CFG_AUTOFIRE1, {15'd0, af1});
    write_cfg(dgpr_pkg::CFG_POTGO_BASE, base);
    cfg_we_i <= 1'b0;
  endtask

  // dirs = {left, up, right, down}, btn = {primary, secondary}
  function automatic dgpr_pkg::in_item_t mk_item(input dgpr_pkg::kind_e k,
                                                 input logic [2:0] sel,
                                                 input logic [15:0] wd,
                                                 input logic [3:0] dev,
                                                 input logic [15:0] mx,
                                                 input logic [15:0] my,
                                                 input logic [3:0] dirs,
                                                 input logic [1:0] btn);
    dgpr_pkg::in_item_t it;
    it.kind           = k;
    it.reg_select     = sel;
    it.write_data     = wd;
    it.device         = dev;
    it.move_x         = mx;
    it.move_y         = my;
    it.dir_left       = dirs[3];
    it.dir_up         = dirs[2];
    it.dir_right      = dirs[1];
    it.dir_down       = dirs[0];
    it.fire_primary   = btn[1];
    it.fire_secondary = btn[0];
    return it;
  endfunction

  function automatic dgpr_pkg::in_item_t read_item(input logic [2:0] sel);
    return mk_item(dgpr_pkg::KIND_READ, sel, '0, '0, '0, '0, '0, '0);
  endfunction

  function automatic dgpr_pkg::in_item_t random_item();
    logic [63:0]        r;
    dgpr_pkg::in_item_t it;
    int unsigned        pick;
    r    = {$urandom, $urandom};
    it   = r[$bits(dgpr_pkg::in_item_t)-1:0];
    pick = $urandom_range(99);
    if (pick < 40) begin
      it.kind = dgpr_pkg::KIND_READ;
      if ($urandom_range(9) == 0) begin
        it.reg_select = 3'($urandom_range(SelUnusedHi, SelUnusedLo));
      end else begin
        it.reg_select = 3'($urandom_range(dgpr_pkg::SEL_POT_STATUS,
                                          dgpr_pkg::SEL_PORT0_DATA));
      end
    end else if (pick < 48) begin
      it.kind = dgpr_pkg::KIND_TEST_WR;
    end else if (pick < 74) begin
      it.kind = dgpr_pkg::KIND_MOUSE;
    end else begin
      it.kind = dgpr_pkg::KIND_JOYSTICK;
    end
    if ($urandom_range(9) < 8) it.device = port_dev_cfg[1'($urandom_range(1))];
    case ($urandom_range(9))
      0: ;
      1, 2, 3: begin
        it.move_x = 16'($urandom_range(1023)) - 16'd512;
        it.move_y = 16'($urandom_range(1023)) - 16'd512;
      end
      default: begin
        it.move_x = 16'($urandom_range(63)) - 16'd32;
        it.move_y = 16'($urandom_range(63)) - 16'd32;
      end
    endcase
    return it;
  endfunction

  task automatic run_random_items(input int n);
    repeat (n) send_item(random_item());
  endtask

  task automatic test_directed_items();
    send_item(read_item(dgpr_pkg::SEL_PORT0_DATA));
    send_item(mk_item(dgpr_pkg::KIND_MOUSE, '0, '0, dgpr_pkg::MouseCode,
                      16'h7fff, 16'h8000, '0, 2'b11));
    send_item(read_item(dgpr_pkg::SEL_PORT0_DATA));
    send_item(read_item(dgpr_pkg::SEL_PORT0_DATA));
    send_item(read_item(dgpr_pkg::SEL_POT0));
    send_item(mk_item(dgpr_pkg::KIND_JOYSTICK, '0, '0, dgpr_pkg::Port1DevReset,
                      '0, '0, 4'b1100, 2'b01));
    send_item(read_item(dgpr_pkg::SEL_PORT1_DATA));
    send_item(mk_item(dgpr_pkg::KIND_JOYSTICK, '0, '0, dgpr_pkg::Port1DevReset,
                      '0, '0, 4'b0011, 2'b10));
    send_item(read_item(dgpr_pkg::SEL_PORT1_DATA));
    send_item(mk_item(dgpr_pkg::KIND_JOYSTICK, '0, '0, dgpr_pkg::Port1DevReset,
                      '0, '0, 4'b1111, 2'b11));
    send_item(read_item(dgpr_pkg::SEL_PORT1_DATA));
    send_item(read_item(dgpr_pkg::SEL_POT1));
    send_item(read_item(dgpr_pkg::SEL_POT_STATUS));
    send_item(read_item(SelUnusedLo));
    send_item(read_item(SelUnusedLo + 3'd1));
    send_item(read_item(SelUnusedHi));
    send_item(mk_item(dgpr_pkg::KIND_TEST_WR, '0, 16'h80ff, '0, '0, '0, '0, '0));
    send_item(read_item(dgpr_pkg::SEL_PORT0_DATA));
    send_item(mk_item(dgpr_pkg::KIND_TEST_WR, '0, 16'h7f01, '0, '0, '0, '0, '0));
    send_item(read_item(dgpr_pkg::SEL_PORT0_DATA));
    // step back across zero
    send_item(mk_item(dgpr_pkg::KIND_MOUSE, '0, '0, dgpr_pkg::MouseCode,
                      16'hff00, 16'h0100, '0, 2'b00));
    send_item(read_item(dgpr_pkg::SEL_PORT0_DATA));
    send_item(mk_item(dgpr_pkg::KIND_JOYSTICK, '0, '0, NoPortDev, '0, '0, 4'b1111, 2'b11));
    send_item(read_item(dgpr_pkg::SEL_PORT1_DATA));
  endtask

  task automatic test_config_phase(input logic [3:0] dev0, input logic [3:0] dev1,
                                   input logic af0, input logic af1,
                                   input logic [15:0] base, input int n);
    apply_setting(dev0, dev1, af0, af1, base);
    run_random_items(n);
  endtask

  task automatic test_backpressure();
    dgpr_pkg::in_item_t it;
    hold_off_req = 1'b1;
    repeat (40) begin
      it      = random_item();
      it.kind = dgpr_pkg::KIND_READ;
      send_item(it);
    end
    run_random_items(60);
  endtask

  task automatic test_steady_stream();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_random_items(150);
    send_idle_pct  = 35;
    recv_stall_pct = 35;
  endtask

  initial begin
    port_dev_cfg[0] = dgpr_pkg::Port0DevReset;
    port_dev_cfg[1] = dgpr_pkg::Port1DevReset;
    potgo_cfg       = dgpr_pkg::PotgoReset;
    for (int p = 0; p < 2; p++) begin
      autofire_cfg[p] = 1'b0;
      pos_x[p]        = '0;
      pos_y[p]        = '0;
      seen_x[p]       = '0;
      seen_y[p]       = '0;
      pot_cnt[p]      = '0;
      fire_main[p]    = 1'b0;
      fire_second[p]  = 1'b0;
      dir_flags[p]    = '0;
    end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_items();
    test_config_phase(dgpr_pkg::MouseCode, dgpr_pkg::Port1DevReset, 1'b0, 1'b0,
                      dgpr_pkg::PotgoReset, 220);
    test_config_phase(4'hf, 4'hf, 1'b1, 1'b1, 16'h0000, 200);
    test_config_phase(4'h0, dgpr_pkg::MouseCode, 1'b1, 1'b0, 16'h4400, 200);
    test_config_phase(dgpr_pkg::MouseCode, dgpr_pkg::MouseCode, 1'b0, 1'b1,
                      dgpr_pkg::PotgoMask, 200);
    test_config_phase(4'($urandom), 4'($urandom), 1'($urandom), 1'($urandom),
                      16'($urandom), 200);
    test_backpressure();
    test_steady_stream();

    wait_reads_done();
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
